FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held
`define ESMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ESMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/esms_pkg.sv
// Types and constants of the encoder-synced motion sequencer
`timescale 1ns / 1ps
`default_nettype none

package esms_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_START      = 2'd0,
    OP_TICK_LEFT  = 2'd1,
    OP_TICK_RIGHT = 2'd2,
    OP_MS         = 2'd3
  } op_t;

  // Move status / wall classification codes
  typedef logic [2:0] wall_code_t;
  localparam wall_code_t WALL_UNCHECKED  = 3'd0;
  localparam wall_code_t WALL_CLEAR      = 3'd1;
  localparam wall_code_t WALL_RIGHT_NEAR = 3'd2;
  localparam wall_code_t WALL_LEFT_NEAR  = 3'd3;
  localparam wall_code_t WALL_RIGHT_FAR  = 3'd4;
  localparam wall_code_t WALL_LEFT_FAR   = 3'd5;
  localparam wall_code_t WALL_TIMEOUT    = 3'd6;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HALTED        = 3'd0;
  localparam cfg_idx_t CFG_FRONT_STOP    = 3'd1;
  localparam cfg_idx_t CFG_WALL_PRESENT  = 3'd2;
  localparam cfg_idx_t CFG_WALL_FAR      = 3'd3;
  localparam cfg_idx_t CFG_WALL_NEAR     = 3'd4;
  localparam cfg_idx_t CFG_TIMEOUT_MS    = 3'd5;

  localparam int CFG_DATA_BITS = 16;
  localparam int LEVEL_BITS    = 10;
  localparam int DRIVE_BITS    = 8;
  localparam int TARGET_BITS   = 16;
  localparam int MS_BITS       = 16;
  localparam int RAMP_BITS     = 11;

  // Configuration reset values
  localparam logic [LEVEL_BITS-1:0] FRONT_STOP_RST   = 10'd300;
  localparam logic [LEVEL_BITS-1:0] WALL_PRESENT_RST = 10'd140;
  localparam logic [LEVEL_BITS-1:0] WALL_FAR_RST     = 10'd150;
  localparam logic [LEVEL_BITS-1:0] WALL_NEAR_RST    = 10'd320;
  localparam logic [MS_BITS-1:0]    TIMEOUT_RST      = 16'd5000;

  // Saturation limits
  localparam logic [RAMP_BITS-1:0] RAMP_MAX = 11'd2047;
  localparam logic [MS_BITS-1:0]   MS_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/encoder_synced_motion_sequencer.sv
// Top level of the encoder-synced two-wheel move sequencer
`timescale 1ns / 1ps
`default_nettype none

// Runs one straight two-wheel move driven by start, encoder-tick and
// millisecond items. Every accepted item yields exactly one result, which
// shows the drive levels and status after that item. The block takes one
// item per clock cycle when not held by back-pressure; the input register
// takes an accepted item, then the state update loads its result into the
// result register when the update stage advances. The result register and
// the input register both hold under back-pressure, so up to two items can
// be in flight. Configuration writes take effect at the clock edge of the
// write and should only be issued while no item is in flight.
module encoder_synced_motion_sequencer
  import esms_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int SENSOR_BITS = 10
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // configuration
  input  wire                      cfg_we,
  input  wire [2:0]                cfg_index,
  input  wire [CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [1:0]                in_operation,
  input  wire [DRIVE_BITS-1:0]     in_start_drive,
  input  wire [DRIVE_BITS-1:0]     in_max_drive,
  input  wire [TARGET_BITS-1:0]    in_tick_target,
  input  wire                      in_use_sensors,
  input  wire                      in_force_decel,
  input  wire [SENSOR_BITS-1:0]    in_front_ir,
  input  wire [SENSOR_BITS-1:0]    in_left_ir,
  input  wire [SENSOR_BITS-1:0]    in_right_ir,
  // result channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [DRIVE_BITS-1:0]    out_drive_left,
  output logic [DRIVE_BITS-1:0]    out_drive_right,
  output logic                     out_moving,
  output logic                     out_finished,
  output logic [2:0]               out_wall_code,
  output logic [LEVEL_BITS-1:0]    out_last_ramp
);

  // Width used when counts, their sum and the target are compared
  localparam int CMP_BITS = (COUNT_BITS + 1 > TARGET_BITS + 1) ? COUNT_BITS + 1
                                                              : TARGET_BITS + 1;

  // ---------------- configuration registers ----------------
  logic                  halted_r;
  logic [LEVEL_BITS-1:0] front_stop_r;
  logic [LEVEL_BITS-1:0] wall_present_r;
  logic [LEVEL_BITS-1:0] wall_far_r;
  logic [LEVEL_BITS-1:0] wall_near_r;
  logic [MS_BITS-1:0]    timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r       <= 1'b0;
      front_stop_r   <= FRONT_STOP_RST;
      wall_present_r <= WALL_PRESENT_RST;
      wall_far_r     <= WALL_FAR_RST;
      wall_near_r    <= WALL_NEAR_RST;
      timeout_r      <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HALTED:       halted_r       <= cfg_data[0];
        CFG_FRONT_STOP:   front_stop_r   <= cfg_data[LEVEL_BITS-1:0];
        CFG_WALL_PRESENT: wall_present_r <= cfg_data[LEVEL_BITS-1:0];
        CFG_WALL_FAR:     wall_far_r     <= cfg_data[LEVEL_BITS-1:0];
        CFG_WALL_NEAR:    wall_near_r    <= cfg_data[LEVEL_BITS-1:0];
        CFG_TIMEOUT_MS:   timeout_r      <= cfg_data[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Thresholds seen at the sensor width
  logic [SENSOR_BITS-1:0] front_thr;
  logic [SENSOR_BITS-1:0] present_thr;
  logic [SENSOR_BITS-1:0] far_thr;
  logic [SENSOR_BITS-1:0] near_thr;

  assign front_thr   = SENSOR_BITS'(front_stop_r);
  assign present_thr = SENSOR_BITS'(wall_present_r);
  assign far_thr     = SENSOR_BITS'(wall_far_r);
  assign near_thr    = SENSOR_BITS'(wall_near_r);

  // ---------------- input register ----------------
  logic                   s1_valid_r;
  op_t                    s1_op_r;
  logic [DRIVE_BITS-1:0]  s1_start_r;
  logic [DRIVE_BITS-1:0]  s1_max_r;
  logic [TARGET_BITS-1:0] s1_target_r;
  logic                   s1_sensors_r;
  logic                   s1_force_r;
  logic [SENSOR_BITS-1:0] s1_front_r;
  logic [SENSOR_BITS-1:0] s1_left_r;
  logic [SENSOR_BITS-1:0] s1_right_r;

  logic advance;
  logic in_xfer;

  // The update stage moves when the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r      <= op_t'(in_operation);
      s1_start_r   <= in_start_drive;
      s1_max_r     <= in_max_drive;
      s1_target_r  <= in_tick_target;
      s1_sensors_r <= in_use_sensors;
      s1_force_r   <= in_force_decel;
      s1_front_r   <= in_front_ir;
      s1_left_r    <= in_left_ir;
      s1_right_r   <= in_right_ir;
    end
  end

  // ---------------- move state ----------------
  logic [COUNT_BITS-1:0]  left_cnt_r,  left_cnt_nxt;
  logic [COUNT_BITS-1:0]  right_cnt_r, right_cnt_nxt;
  logic [RAMP_BITS-1:0]   ramp_r,      ramp_nxt;
  logic [MS_BITS-1:0]     elapsed_r,   elapsed_nxt;
  logic                   active_r,    active_nxt;
  wall_code_t             code_r,      code_nxt;
  logic [LEVEL_BITS-1:0]  rec_ramp_r,  rec_ramp_nxt;
  logic [DRIVE_BITS-1:0]  mp_start_r,  mp_start_nxt;
  logic [DRIVE_BITS-1:0]  mp_max_r,    mp_max_nxt;
  logic [TARGET_BITS-1:0] mp_target_r, mp_target_nxt;
  logic                   mp_sensors_r, mp_sensors_nxt;
  logic                   mp_force_r,  mp_force_nxt;
  logic                   fin;

  // Wall classification of the side readings
  function automatic wall_code_t classify(
    input logic [SENSOR_BITS-1:0] l,
    input logic [SENSOR_BITS-1:0] r,
    input logic [SENSOR_BITS-1:0] near,
    input logic [SENSOR_BITS-1:0] pres,
    input logic [SENSOR_BITS-1:0] far
  );
    wall_code_t c;
    if (r > near) begin
      c = WALL_RIGHT_NEAR;
    end else if (l > near) begin
      c = WALL_LEFT_NEAR;
    end else if (r > pres && r < far) begin
      c = WALL_RIGHT_FAR;
    end else if (l > pres && l < far) begin
      c = WALL_LEFT_FAR;
    end else begin
      c = WALL_CLEAR;
    end
    return c;
  endfunction

  // Current counts against the loaded target
  logic [CMP_BITS-1:0] target_ext;
  logic [CMP_BITS-1:0] count_sum;
  logic                cur_reached;
  logic                tick_reached;
  logic                front_block;

  assign target_ext  = CMP_BITS'(mp_target_r);
  assign count_sum   = CMP_BITS'(left_cnt_r) + CMP_BITS'(right_cnt_r);
  assign cur_reached = (CMP_BITS'(left_cnt_r) >= target_ext) &&
                       (CMP_BITS'(right_cnt_r) >= target_ext);
  assign tick_reached = (CMP_BITS'(left_cnt_nxt) >= target_ext) &&
                        (CMP_BITS'(right_cnt_nxt) >= target_ext);
  assign front_block = mp_sensors_r && (s1_front_r > front_thr);

  // Next-state logic for one item
  always_comb begin
    left_cnt_nxt   = left_cnt_r;
    right_cnt_nxt  = right_cnt_r;
    ramp_nxt       = ramp_r;
    elapsed_nxt    = elapsed_r;
    active_nxt     = active_r;
    code_nxt       = code_r;
    rec_ramp_nxt   = rec_ramp_r;
    mp_start_nxt   = mp_start_r;
    mp_max_nxt     = mp_max_r;
    mp_target_nxt  = mp_target_r;
    mp_sensors_nxt = mp_sensors_r;
    mp_force_nxt   = mp_force_r;
    fin            = 1'b0;

    case (s1_op_r)
      OP_START: begin
        if (halted_r) begin
          active_nxt = 1'b0;
          code_nxt   = WALL_UNCHECKED;
          fin        = 1'b1;
        end else begin
          mp_start_nxt   = s1_start_r;
          mp_max_nxt     = s1_max_r;
          mp_target_nxt  = s1_target_r;
          mp_sensors_nxt = s1_sensors_r;
          mp_force_nxt   = s1_force_r;
          left_cnt_nxt   = '0;
          right_cnt_nxt  = '0;
          ramp_nxt       = RAMP_BITS'({s1_start_r, 1'b0});
          elapsed_nxt    = '0;
          code_nxt       = WALL_UNCHECKED;
          active_nxt     = 1'b1;
          // zero target: done as soon as it starts
          if (s1_target_r == '0) begin
            active_nxt   = 1'b0;
            rec_ramp_nxt = LEVEL_BITS'(s1_start_r);
            fin          = 1'b1;
          end
        end
      end
      OP_TICK_LEFT, OP_TICK_RIGHT: begin
        if (s1_op_r == OP_TICK_LEFT) begin
          if (left_cnt_r != '1) left_cnt_nxt = left_cnt_r + 1'b1;
        end else begin
          if (right_cnt_r != '1) right_cnt_nxt = right_cnt_r + 1'b1;
        end
        if (active_r && tick_reached) begin
          active_nxt   = 1'b0;
          rec_ramp_nxt = ramp_r[RAMP_BITS-1:1];
          fin          = 1'b1;
        end
      end
      OP_MS: begin
        if (active_r) begin
          if (elapsed_r != MS_MAX) elapsed_nxt = elapsed_r + 1'b1;
          if (cur_reached || front_block) begin
            active_nxt   = 1'b0;
            rec_ramp_nxt = ramp_r[RAMP_BITS-1:1];
            fin          = 1'b1;
          end else if (elapsed_nxt > timeout_r) begin
            active_nxt = 1'b0;
            code_nxt   = WALL_TIMEOUT;
            fin        = 1'b1;
          end else if (count_sum < target_ext ||
                       (code_r == WALL_CLEAR && !mp_force_r)) begin
            if (ramp_r != RAMP_MAX) ramp_nxt = ramp_r + 1'b1;
          end else if (code_r == WALL_UNCHECKED) begin
            code_nxt = classify(s1_left_r, s1_right_r, near_thr, present_thr, far_thr);
          end else begin
            ramp_nxt = RAMP_BITS'({mp_start_r, 1'b0});
          end
        end
      end
      default: ;
    endcase
  end

  // State registers, updated when an item leaves the input register
  logic update;
  assign update = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      ramp_r      <= '0;
      elapsed_r   <= '0;
      active_r    <= 1'b0;
      code_r      <= WALL_UNCHECKED;
      rec_ramp_r  <= '0;
    end else if (update) begin
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
      ramp_r      <= ramp_nxt;
      elapsed_r   <= elapsed_nxt;
      active_r    <= active_nxt;
      code_r      <= code_nxt;
      rec_ramp_r  <= rec_ramp_nxt;
    end
  end

  // Move parameters are only read while a move is active
  always_ff @(posedge clk) begin
    if (update) begin
      mp_start_r   <= mp_start_nxt;
      mp_max_r     <= mp_max_nxt;
      mp_target_r  <= mp_target_nxt;
      mp_sensors_r <= mp_sensors_nxt;
      mp_force_r   <= mp_force_nxt;
    end
  end

  // ---------------- drive levels after the item ----------------
  logic [LEVEL_BITS-1:0] pwm_full;
  logic [DRIVE_BITS-1:0] pwm;
  logic [DRIVE_BITS-1:0] drive_l;
  logic [DRIVE_BITS-1:0] drive_r;

  assign pwm_full = ramp_nxt[RAMP_BITS-1:1];

  always_comb begin
    if (pwm_full > LEVEL_BITS'(mp_max_nxt)) begin
      pwm = mp_max_nxt;
    end else begin
      pwm = pwm_full[DRIVE_BITS-1:0];
    end
    drive_l = '0;
    drive_r = '0;
    // the wheel that is ahead is switched off
    if (active_nxt) begin
      drive_l = (left_cnt_nxt > right_cnt_nxt) ? '0 : pwm;
      drive_r = (left_cnt_nxt < right_cnt_nxt) ? '0 : pwm;
    end
  end

  // ---------------- result register ----------------
  logic                  out_valid_r;
  logic [DRIVE_BITS-1:0] out_drive_left_r;
  logic [DRIVE_BITS-1:0] out_drive_right_r;
  logic                  out_moving_r;
  logic                  out_finished_r;
  wall_code_t            out_wall_code_r;
  logic [LEVEL_BITS-1:0] out_last_ramp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_drive_left_r  <= drive_l;
      out_drive_right_r <= drive_r;
      out_moving_r      <= active_nxt;
      out_finished_r    <= fin;
      out_wall_code_r   <= code_nxt;
      out_last_ramp_r   <= rec_ramp_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_left  = out_drive_left_r;
  assign out_drive_right = out_drive_right_r;
  assign out_moving      = out_moving_r;
  assign out_finished    = out_finished_r;
  assign out_wall_code   = out_wall_code_r;
  assign out_last_ramp   = out_last_ramp_r;

endmodule

`default_nettype wire

FILE: rtl/esms_checker.sv
// Port-level checker for the motion sequencer, with its bind statement
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module esms_checker
  import esms_pkg::*;
(
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [DRIVE_BITS-1:0]  out_drive_left,
  input wire [DRIVE_BITS-1:0]  out_drive_right,
  input wire                   out_moving,
  input wire                   out_finished,
  input wire [2:0]             out_wall_code,
  input wire [LEVEL_BITS-1:0]  out_last_ramp
);

  // a stalled result keeps its payload
  `ESMS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_drive_left) && $stable(out_drive_right) && $stable(out_moving) && $stable(out_finished) && $stable(out_wall_code) && $stable(out_last_ramp), "result changed while stalled")

  // no drive without an active move
  `ESMS_ASSERT(a_idle_no_drive, out_valid && !out_moving |-> out_drive_left == '0 && out_drive_right == '0, "drive while idle")

  // the transfer that ends a move shows it stopped
  `ESMS_ASSERT(a_finish_stops, out_valid && out_finished |-> !out_moving, "finished while moving")

  // one wheel off, or both at the same level
  `ESMS_ASSERT(a_drive_sync, out_valid |-> out_drive_left == '0 || out_drive_right == '0 || out_drive_left == out_drive_right, "wheels driven at different levels")

  // a timeout never leaves a move running
  `ESMS_ASSERT(a_timeout_idle, out_valid && out_wall_code == WALL_TIMEOUT |-> !out_moving, "timeout code while moving")

endmodule

bind encoder_synced_motion_sequencer esms_checker u_esms_checker (.*);

`default_nettype wire

FILE: tb/sv/encoder_synced_motion_sequencer_tb.sv
// Self-checking testbench for the encoder-synced two-wheel move sequencer
`timescale 1ns / 1ps

module encoder_synced_motion_sequencer_tb;
  import esms_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CNT_BITS     = 16;
  localparam int IR_BITS      = 10;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 250;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASES       = 6;
  localparam int BURST_LEN    = 60;

  // One input transfer
  typedef struct packed {
    op_t                    op;
    logic [DRIVE_BITS-1:0]  start_drv;
    logic [DRIVE_BITS-1:0]  max_drv;
    logic [TARGET_BITS-1:0] target;
    logic                   sensors;
    logic                   decel;
    logic [IR_BITS-1:0]     front;
    logic [IR_BITS-1:0]     left;
    logic [IR_BITS-1:0]     right;
  } move_item_t;

  // One result transfer, in port order
  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive_l;
    logic [DRIVE_BITS-1:0] drive_r;
    logic                  moving;
    logic                  finished;
    wall_code_t            code;
    logic [LEVEL_BITS-1:0] ramp_rec;
  } drive_status_t;

  // Directed script row: a register write or an item, optionally with a typed result
  typedef struct packed {
    logic                     is_cfg;
    cfg_idx_t                 idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic                     typed;
    move_item_t               item;
    drive_status_t            golden;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_operation;
  logic [DRIVE_BITS-1:0] in_start_drive;
  logic [DRIVE_BITS-1:0] in_max_drive;
  logic [TARGET_BITS-1:0] in_tick_target;
  logic in_use_sensors;
  logic in_force_decel;
  logic [IR_BITS-1:0] in_front_ir;
  logic [IR_BITS-1:0] in_left_ir;
  logic [IR_BITS-1:0] in_right_ir;
  logic out_valid;
  logic out_ready;
  logic [DRIVE_BITS-1:0] out_drive_left;
  logic [DRIVE_BITS-1:0] out_drive_right;
  logic out_moving;
  logic out_finished;
  logic [2:0] out_wall_code;
  logic [LEVEL_BITS-1:0] out_last_ramp;

  encoder_synced_motion_sequencer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_start_drive (in_start_drive),
    .in_max_drive   (in_max_drive),
    .in_tick_target (in_tick_target),
    .in_use_sensors (in_use_sensors),
    .in_force_decel (in_force_decel),
    .in_front_ir    (in_front_ir),
    .in_left_ir     (in_left_ir),
    .in_right_ir    (in_right_ir),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive_left (out_drive_left),
    .out_drive_right(out_drive_right),
    .out_moving     (out_moving),
    .out_finished   (out_finished),
    .out_wall_code  (out_wall_code),
    .out_last_ramp  (out_last_ramp)
  );

  // Clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Predicted sequencer state and register copy
  logic [CNT_BITS-1:0]    m_left, m_right;
  logic [RAMP_BITS-1:0]   m_ramp;
  logic [MS_BITS-1:0]     m_ms;
  logic                   m_active;
  wall_code_t             m_code;
  logic [LEVEL_BITS-1:0]  m_rec;
  logic [DRIVE_BITS-1:0]  mv_start, mv_max;
  logic [TARGET_BITS-1:0] mv_target;
  logic                   mv_sensors, mv_force;
  logic                   c_halted;
  logic [LEVEL_BITS-1:0]  c_front, c_present, c_far, c_near;
  logic [MS_BITS-1:0]     c_timeout;

  drive_status_t expected_status[$];
  script_row_t   script[$];

  int  items_sent;
  int  results_checked;
  int  fail_count;
  int  idle_cycles;
  int  move_ends;
  bit  [6:0] codes_seen;
  bit  hold_req;
  bit  steady_mode;

  function automatic void reset_model();
    m_left = '0; m_right = '0; m_ramp = '0; m_ms = '0;
    m_active = 1'b0; m_code = WALL_UNCHECKED; m_rec = '0;
    mv_start = '0; mv_max = '0; mv_target = '0; mv_sensors = 1'b0; mv_force = 1'b0;
    c_halted = 1'b0;
    c_front = FRONT_STOP_RST; c_present = WALL_PRESENT_RST;
    c_far = WALL_FAR_RST; c_near = WALL_NEAR_RST; c_timeout = TIMEOUT_RST;
  endfunction

  function automatic wall_code_t sort_walls(logic [IR_BITS-1:0] l, logic [IR_BITS-1:0] r);
    if (r > c_near) return WALL_RIGHT_NEAR;
    if (l > c_near) return WALL_LEFT_NEAR;
    if (r > c_present && r < c_far) return WALL_RIGHT_FAR;
    if (l > c_present && l < c_far) return WALL_LEFT_FAR;
    return WALL_CLEAR;
  endfunction

  function automatic logic both_at_target();
    return (m_left >= mv_target) && (m_right >= mv_target);
  endfunction

  // Advances the predicted state by one item and returns the status it shows
  function automatic drive_status_t advance_move(move_item_t it);
    drive_status_t res;
    logic done;
    logic [LEVEL_BITS-1:0] pwm;
    done = 1'b0;
    case (it.op)
      OP_START: begin
        if (c_halted) begin
          m_active = 1'b0;
          m_code = WALL_UNCHECKED;
          done = 1'b1;
        end else begin
          mv_start = it.start_drv;
          mv_max = it.max_drv;
          mv_target = it.target;
          mv_sensors = it.sensors;
          mv_force = it.decel;
          m_left = '0;
          m_right = '0;
          m_ramp = {2'b00, it.start_drv, 1'b0};
          m_ms = '0;
          m_code = WALL_UNCHECKED;
          m_active = 1'b1;
          if (both_at_target()) begin
            m_active = 1'b0;
            m_rec = m_ramp[RAMP_BITS-1:1];
            done = 1'b1;
          end
        end
      end
      OP_TICK_LEFT, OP_TICK_RIGHT: begin
        if (it.op == OP_TICK_LEFT) begin
          if (m_left != '1) m_left++;
        end else begin
          if (m_right != '1) m_right++;
        end
        if (m_active && both_at_target()) begin
          m_active = 1'b0;
          m_rec = m_ramp[RAMP_BITS-1:1];
          done = 1'b1;
        end
      end
      default: begin
        if (m_active) begin
          if (m_ms != MS_MAX) m_ms++;
          if (both_at_target() || (mv_sensors && it.front > c_front)) begin
            m_active = 1'b0;
            m_rec = m_ramp[RAMP_BITS-1:1];
            done = 1'b1;
          end else if (m_ms > c_timeout) begin
            m_active = 1'b0;
            m_code = WALL_TIMEOUT;
            done = 1'b1;
          end else if (({1'b0, m_left} + {1'b0, m_right}) < {1'b0, mv_target} ||
                       (m_code == WALL_CLEAR && !mv_force)) begin
            if (m_ramp != RAMP_MAX) m_ramp++;
          end else if (m_code == WALL_UNCHECKED) begin
            m_code = sort_walls(it.left, it.right);
          end else begin
            m_ramp = {2'b00, mv_start, 1'b0};
          end
        end
      end
    endcase
    // Drive: ramp without its low bit, capped at max; the wheel that is ahead is off
    pwm = m_ramp[RAMP_BITS-1:1];
    if (pwm > LEVEL_BITS'(mv_max)) pwm = LEVEL_BITS'(mv_max);
    res.drive_l = (m_active && !(m_left > m_right)) ? pwm[DRIVE_BITS-1:0] : '0;
    res.drive_r = (m_active && !(m_left < m_right)) ? pwm[DRIVE_BITS-1:0] : '0;
    res.moving = m_active;
    res.finished = done;
    res.code = m_code;
    res.ramp_rec = m_rec;
    return res;
  endfunction

  // Stimulus helpers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic move_item_t mk_item(op_t op, int sd, int md, int tgt, int sens, int dec,
                                         int f, int l, int r);
    move_item_t it;
    it.op = op;
    it.start_drv = DRIVE_BITS'(sd);
    it.max_drv = DRIVE_BITS'(md);
    it.target = TARGET_BITS'(tgt);
    it.sensors = 1'(sens);
    it.decel = 1'(dec);
    it.front = IR_BITS'(f);
    it.left = IR_BITS'(l);
    it.right = IR_BITS'(r);
    return it;
  endfunction

  function automatic drive_status_t status(int dl, int dr, int mv, int fin, wall_code_t code,
                                           int rec);
    drive_status_t s;
    s.drive_l = DRIVE_BITS'(dl); s.drive_r = DRIVE_BITS'(dr);
    s.moving = 1'(mv); s.finished = 1'(fin);
    s.code = code; s.ramp_rec = LEVEL_BITS'(rec);
    return s;
  endfunction

  function automatic void add_cfg(cfg_idx_t idx, int data);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1; row.idx = idx; row.data = CFG_DATA_BITS'(data);
    script.push_back(row);
  endfunction

  function automatic void add_item(move_item_t it, int typed, drive_status_t golden);
    script_row_t row;
    row = '0;
    row.item = it; row.typed = 1'(typed); row.golden = golden;
    script.push_back(row);
  endfunction

  // All fields random, including those the operation ignores
  function automatic move_item_t junk_item(op_t op);
    move_item_t it;
    it.op = op;
    it.start_drv = DRIVE_BITS'($urandom_range(0, 255));
    it.max_drv = DRIVE_BITS'($urandom_range(0, 255));
    it.target = TARGET_BITS'($urandom_range(0, 65535));
    it.sensors = 1'($urandom_range(0, 1));
    it.decel = 1'($urandom_range(0, 1));
    it.front = IR_BITS'($urandom_range(0, 1023));
    it.left = IR_BITS'($urandom_range(0, 1023));
    it.right = IR_BITS'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic logic [IR_BITS-1:0] around(logic [IR_BITS-1:0] lvl);
    int v;
    v = int'(lvl) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[IR_BITS-1:0];
  endfunction

  // Side readings cluster around the wall thresholds
  function automatic logic [IR_BITS-1:0] pick_side();
    case ($urandom_range(0, 4))
      0: return IR_BITS'($urandom_range(0, 1023));
      1: return around(c_present);
      2: return around(c_far);
      3: return around(c_near);
      default: return IR_BITS'($urandom_range(0, c_present));
    endcase
  endfunction

  function automatic logic [IR_BITS-1:0] pick_front();
    if ($urandom_range(0, 99) < 85) return IR_BITS'($urandom_range(0, c_front));
    return IR_BITS'($urandom_range(0, 1023));
  endfunction

  function automatic logic [DRIVE_BITS-1:0] pick_drive();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DRIVE_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [TARGET_BITS-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return TARGET_BITS'($urandom_range(1, 8));
    if (r < 95) return TARGET_BITS'($urandom_range(9, 40));
    return TARGET_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic move_item_t random_event();
    move_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it = junk_item(OP_MS);
      it.front = pick_front();
      it.left = pick_side();
      it.right = pick_side();
    end else if (r < 70) begin
      it = junk_item(OP_TICK_LEFT);
    end else if (r < 97) begin
      it = junk_item(OP_TICK_RIGHT);
    end else begin
      // restart in the middle of a move
      it = junk_item(OP_START);
      it.target = pick_target();
    end
    return it;
  endfunction

  // Offers one item, holds it until the transfer, then predicts its status
  task automatic send_item(move_item_t it, bit typed, drive_status_t golden);
    int gap;
    drive_status_t predicted;
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_start_drive <= it.start_drv;
    in_max_drive <= it.max_drv;
    in_tick_target <= it.target;
    in_use_sensors <= it.sensors;
    in_force_decel <= it.decel;
    in_front_ir <= it.front;
    in_left_ir <= it.left;
    in_right_ir <= it.right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_move(it);
    expected_status.push_back(typed ? golden : predicted);
    items_sent++;
  endtask

  // Register write once the block has drained
  task automatic write_reg(cfg_idx_t idx, int data);
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HALTED:       c_halted = data[0];
      CFG_FRONT_STOP:   c_front = data[LEVEL_BITS-1:0];
      CFG_WALL_PRESENT: c_present = data[LEVEL_BITS-1:0];
      CFG_WALL_FAR:     c_far = data[LEVEL_BITS-1:0];
      CFG_WALL_NEAR:    c_near = data[LEVEL_BITS-1:0];
      CFG_TIMEOUT_MS:   c_timeout = data[MS_BITS-1:0];
      default: ;
    endcase
  endtask

  // A start followed by random ticks until the move ends or the budget runs out
  task automatic random_move();
    move_item_t it;
    int budget;
    int k;
    it = junk_item(OP_START);
    it.start_drv = pick_drive();
    it.max_drv = pick_drive();
    it.target = pick_target();
    send_item(it, 1'b0, '0);
    budget = $urandom_range(4, 40);
    k = 0;
    while (m_active && k < budget) begin
      send_item(random_event(), 1'b0, '0);
      k++;
    end
    // stray items after the end
    repeat ($urandom_range(0, 2)) send_item(random_event(), 1'b0, '0);
  endtask

  task automatic set_phase(int p);
    int lvl;
    case (p)
      0: begin
        write_reg(CFG_FRONT_STOP, 300);
        write_reg(CFG_WALL_PRESENT, 140);
        write_reg(CFG_WALL_FAR, 150);
        write_reg(CFG_WALL_NEAR, 320);
        write_reg(CFG_TIMEOUT_MS, 30);
      end
      1: begin
        write_reg(CFG_FRONT_STOP, $urandom_range(0, 1023));
        write_reg(CFG_WALL_PRESENT, $urandom_range(0, 1023));
        write_reg(CFG_WALL_FAR, $urandom_range(0, 1023));
        write_reg(CFG_WALL_NEAR, $urandom_range(0, 1023));
        write_reg(CFG_TIMEOUT_MS, $urandom_range(3, 60));
      end
      2: begin
        write_reg(CFG_FRONT_STOP, 0);
        write_reg(CFG_WALL_PRESENT, 0);
        write_reg(CFG_WALL_FAR, 0);
        write_reg(CFG_WALL_NEAR, 0);
        write_reg(CFG_TIMEOUT_MS, 65535);
      end
      3: begin
        write_reg(CFG_FRONT_STOP, 1023);
        write_reg(CFG_WALL_PRESENT, 1023);
        write_reg(CFG_WALL_FAR, 1023);
        write_reg(CFG_WALL_NEAR, 1023);
        write_reg(CFG_TIMEOUT_MS, 1);
      end
      4: write_reg(CFG_HALTED, 1);
      default: begin
        // ordered thresholds so every wall class can appear
        write_reg(CFG_HALTED, 0);
        lvl = $urandom_range(0, 300);
        write_reg(CFG_WALL_PRESENT, lvl);
        lvl = lvl + $urandom_range(2, 40);
        write_reg(CFG_WALL_FAR, lvl);
        write_reg(CFG_WALL_NEAR, lvl + $urandom_range(0, 200));
        write_reg(CFG_FRONT_STOP, $urandom_range(200, 900));
        write_reg(CFG_TIMEOUT_MS, 25);
      end
    endcase
  endtask

  // Result side: random ready, long hold-off on request, always ready in steady mode
  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady_mode) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Result check against the oldest expectation; also feeds the watchdog
  always @(posedge clk) begin : result_check
    drive_status_t got;
    drive_status_t want;
    got = {out_drive_left, out_drive_right, out_moving, out_finished, out_wall_code,
           out_last_ramp};
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        if (got.finished === 1'b1) begin
          move_ends++;
          if (got.code <= WALL_TIMEOUT) codes_seen[got.code] = 1'b1;
        end
        if (got.drive_l !== want.drive_l || got.drive_r !== want.drive_r ||
            got.moving !== want.moving || got.finished !== want.finished ||
            got.code !== want.code || got.ramp_rec !== want.ramp_rec) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result %0d: expected L%0d R%0d mv%0b fin%0b code%0d ramp%0d, got L%0d R%0d mv%0b fin%0b code%0d ramp%0d",
                     $time, results_checked, want.drive_l, want.drive_r, want.moving,
                     want.finished, want.code, want.ramp_rec, got.drive_l, got.drive_r,
                     got.moving, got.finished, got.code, got.ramp_rec);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing transfers for too long
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("encoder_synced_motion_sequencer regression: fail");
    $finish;
  end

  initial begin : main_flow
    int quota;
    move_item_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_operation = '0; in_start_drive = '0; in_max_drive = '0;
    in_tick_target = '0; in_use_sensors = 1'b0; in_force_decel = 1'b0;
    in_front_ir = '0; in_left_ir = '0; in_right_ir = '0;
    items_sent = 0; results_checked = 0; fail_count = 0; idle_cycles = 0;
    move_ends = 0; codes_seen = '0; hold_req = 1'b0; steady_mode = 1'b0;
    reset_model();

    // Directed script
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 1023, 1023, 1023), 1,
             status(0, 0, 0, 0, WALL_UNCHECKED, 0));                 // idle ms: no effect
    add_item(mk_item(OP_TICK_LEFT, 0, 0, 0, 0, 0, 0, 0, 0), 1,
             status(0, 0, 0, 0, WALL_UNCHECKED, 0));                 // tick while idle
    add_item(mk_item(OP_START, 10, 20, 0, 0, 0, 0, 0, 0), 1,
             status(0, 0, 0, 1, WALL_UNCHECKED, 10));                // zero target ends at once
    add_item(mk_item(OP_START, 255, 255, 65535, 1, 0, 0, 0, 0), 1,
             status(255, 255, 1, 0, WALL_UNCHECKED, 10));
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 1023, 0, 0), 1,
             status(0, 0, 0, 1, WALL_UNCHECKED, 255));               // front sensor stop
    add_item(mk_item(OP_START, 4, 3, 1, 0, 1, 0, 0, 0), 1,
             status(3, 3, 1, 0, WALL_UNCHECKED, 255));               // drive capped at max
    add_item(mk_item(OP_TICK_LEFT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 1023, 1023, 0), 0, '0);  // left near
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);        // decel back to start
    add_item(mk_item(OP_TICK_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_cfg(CFG_TIMEOUT_MS, 1);
    add_item(mk_item(OP_START, 1, 255, 100, 0, 0, 0, 0, 0), 1,
             status(1, 1, 1, 0, WALL_UNCHECKED, 4));
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 0, 0, 0), 1,
             status(0, 0, 0, 1, WALL_TIMEOUT, 4));                   // timeout keeps ramp record
    add_cfg(CFG_TIMEOUT_MS, 65535);
    add_cfg(CFG_HALTED, 1);
    add_item(mk_item(OP_START, 9, 9, 5, 1, 1, 0, 0, 0), 1,
             status(0, 0, 0, 1, WALL_UNCHECKED, 4));                 // halted start
    add_cfg(CFG_HALTED, 0);
    add_item(mk_item(OP_START, 0, 0, 2, 1, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_TICK_LEFT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_TICK_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 300, 0, 1023), 0, '0);   // front at level, right near
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 301, 0, 0), 0, '0);      // just above stop level
    add_item(mk_item(OP_START, 200, 100, 3, 0, 1, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_START, 50, 60, 1, 0, 0, 0, 0, 0), 0, '0);   // replaces running move
    add_item(mk_item(OP_TICK_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(OP_MS, 0, 0, 0, 0, 0, 0, 145, 0), 0, '0);      // left far
    add_item(mk_item(OP_TICK_LEFT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].idx, int'(script[i].data));
      else send_item(script[i].item, script[i].typed, script[i].golden);
    end

    // Back-to-back burst: a long move with the ramp rising every millisecond
    steady_mode = 1'b1;
    send_item(mk_item(OP_START, 255, 200, 65535, 1, 0, 0, 0, 0), 1'b0, '0);
    repeat (BURST_LEN) begin
      it = junk_item(OP_MS);
      it.front = IR_BITS'($urandom_range(0, c_front));
      send_item(it, 1'b0, '0);
    end
    steady_mode = 1'b0;

    // Random moves under several register settings
    for (int p = 0; p < PHASES; p++) begin
      set_phase(p);
      if (p == 1 || p == 5) hold_req = 1'b1;
      quota = items_sent + ((p == 4) ? 40 : 145);
      while (items_sent < quota) random_move();
    end

    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d items and %0d checked results, with a back-to-back burst",
             items_sent, results_checked);
    $display("Moves ended: %0d; end codes seen (bit per code, timeout is msb): %b",
             move_ends, codes_seen);
    if (fail_count == 0) begin
      $display("encoder_synced_motion_sequencer regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("encoder_synced_motion_sequencer regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/esms_pkg.sv
rtl/encoder_synced_motion_sequencer.sv
rtl/esms_checker.sv
tb/sv/encoder_synced_motion_sequencer_tb.sv
